### hdl/mats_pkg.sv
// Shared constants, types and colour helpers for the multi-ant turmite step unit.
`default_nettype none

package mats_pkg;

  localparam int unsigned GRID_COLUMNS = 56;
  localparam int unsigned GRID_ROWS    = 24;
  localparam int unsigned ANT_COUNT    = 6;
  localparam int unsigned CELL_COUNT   = GRID_COLUMNS * GRID_ROWS;

  localparam int unsigned ADDR_W   = $clog2(CELL_COUNT);
  localparam int unsigned ANT_W    = (ANT_COUNT > 1) ? $clog2(ANT_COUNT) : 1;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IDXC_W   = 5;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned HEAD_W   = 2;
  localparam int unsigned TURN_W   = 5;
  localparam int unsigned COLOUR_W = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  localparam logic [HEAD_W-1:0] HEAD_POS_X = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_POS_Y = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_NEG_X = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_NEG_Y = 2'd3;

  typedef logic [COLOUR_W-1:0] colour_t;

  localparam colour_t PAINT_BLACK  = 3'd0;
  localparam colour_t PAINT_YELLOW = 3'd4;

  typedef struct packed {
    logic             load;
    logic             advance;
    logic [ANT_W-1:0] sel;
  } ant_ctl_t;

  // codes above yellow read as black
  function automatic colour_t clean_colour(input colour_t c);
    return (c > PAINT_YELLOW) ? PAINT_BLACK : c;
  endfunction

  function automatic colour_t next_colour(input colour_t c);
    colour_t s;
    s = clean_colour(c);
    return (s == PAINT_YELLOW) ? PAINT_BLACK : colour_t'(s + 1'b1);
  endfunction

endpackage

`default_nettype wire

### hdl/mats_grid_mem.sv
// Grid colour memory: one write port, one registered read port.
`default_nettype none

module mats_grid_mem
  import mats_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire colour_t           wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output colour_t                rdata_o
);

  colour_t mem [CELL_COUNT];
  colour_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/mats_ant_file.sv
// Ant state registers with the shared turn-and-step unit.
`default_nettype none

module mats_ant_file
  import mats_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ant_ctl_t          ctl_i,
  input  wire logic [COL_W-1:0]  start_x_i,
  input  wire logic [ROW_W-1:0]  start_y_i,
  input  wire logic [HEAD_W-1:0] start_heading_i,
  input  wire logic [TURN_W-1:0] turn_rules_i,
  input  wire colour_t           seen_i,
  output logic [COL_W-1:0]       col_o,
  output logic [ROW_W-1:0]       row_o
);

  logic [COL_W-1:0]  col_q  [ANT_COUNT];
  logic [ROW_W-1:0]  row_q  [ANT_COUNT];
  logic [HEAD_W-1:0] head_q [ANT_COUNT];
  logic [TURN_W-1:0] turn_q [ANT_COUNT];

  logic [HEAD_W-1:0] cur_head, new_head;
  logic [TURN_W-1:0] cur_turn;
  logic [COL_W-1:0]  new_col, ld_col;
  logic [ROW_W-1:0]  new_row, ld_row;
  colour_t           seen;

  always_comb begin
    col_o    = col_q[ctl_i.sel];
    row_o    = row_q[ctl_i.sel];
    cur_head = head_q[ctl_i.sel];
    cur_turn = turn_q[ctl_i.sel];
    seen     = clean_colour(seen_i);
    new_head = cur_turn[seen] ? HEAD_W'(cur_head + 1'b1) : HEAD_W'(cur_head - 1'b1);
    new_col  = col_o;
    new_row  = row_o;
    case (new_head)
      HEAD_POS_X: begin
        new_col = (col_o == COL_W'(GRID_COLUMNS - 1)) ? '0 : COL_W'(col_o + 1'b1);
      end
      HEAD_POS_Y: begin
        new_row = (row_o == ROW_W'(GRID_ROWS - 1)) ? '0 : ROW_W'(row_o + 1'b1);
      end
      HEAD_NEG_X: begin
        new_col = (col_o == '0) ? COL_W'(GRID_COLUMNS - 1) : COL_W'(col_o - 1'b1);
      end
      HEAD_NEG_Y: begin
        new_row = (row_o == '0) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(row_o - 1'b1);
      end
      default: begin
        new_col = col_o;
      end
    endcase
    // inputs stay below twice the grid size, one subtract reduces them
    ld_col = (start_x_i >= COL_W'(GRID_COLUMNS)) ?
             COL_W'(start_x_i - COL_W'(GRID_COLUMNS)) : start_x_i;
    ld_row = (start_y_i >= ROW_W'(GRID_ROWS)) ?
             ROW_W'(start_y_i - ROW_W'(GRID_ROWS)) : start_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ANT_COUNT; i++) begin
        col_q[i]  <= '0;
        row_q[i]  <= '0;
        head_q[i] <= '0;
        turn_q[i] <= '0;
      end
    end else if (ctl_i.load) begin
      col_q[ctl_i.sel]  <= ld_col;
      row_q[ctl_i.sel]  <= ld_row;
      head_q[ctl_i.sel] <= start_heading_i;
      turn_q[ctl_i.sel] <= turn_rules_i;
    end else if (ctl_i.advance) begin
      col_q[ctl_i.sel]  <= new_col;
      row_q[ctl_i.sel]  <= new_row;
      head_q[ctl_i.sel] <= new_head;
    end
  end

endmodule

`default_nettype wire

### hdl/multi_ant_turmite_step_unit.sv
// Top level: command sequencer for the multi-ant turmite grid.
// In a tick each of the ants in turn reads its cell from the grid memory in FETCH and
// writes the new colour back in PAINT, so results come one per ant, each held for
// one cycle on result_valid_o; the receiver cannot stall them. A load is taken in
// the idle state without raising busy. A clear, and the pass that follows reset,
// sweeps the grid memory one cell a cycle over all 1344 cells with busy high.
`default_nettype none

module multi_ant_turmite_step_unit
  import mats_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [IDX_W-1:0]  ant_index_i,
  input  wire logic [COL_W-1:0]  start_x_i,
  input  wire logic [ROW_W-1:0]  start_y_i,
  input  wire logic [HEAD_W-1:0] start_heading_i,
  input  wire logic [TURN_W-1:0] turn_rules_i,
  output logic                   result_valid_o,
  output logic [COL_W-1:0]       pixel_x_o,
  output logic [ROW_W-1:0]       pixel_y_o,
  output logic [COLOUR_W-1:0]    pixel_colour_o,
  output logic                   last_of_tick_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_PAINT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ANT_W-1:0]  ant_q, ant_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              valid_q, valid_d;
  logic              last_q, last_d;
  logic [COL_W-1:0]  px_q, px_d;
  logic [ROW_W-1:0]  py_q, py_d;
  colour_t           pc_q, pc_d;

  ant_ctl_t          ctl;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  colour_t           seen, fresh;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, cell_addr;
  colour_t           mem_wdata;

  mats_ant_file u_ants (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .start_heading_i (start_heading_i),
    .turn_rules_i    (turn_rules_i),
    .seen_i          (seen),
    .col_o           (cur_col),
    .row_o           (cur_row)
  );

  mats_grid_mem u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cell_addr),
    .rdata_o (seen)
  );

  assign fresh     = next_colour(seen);
  assign cell_addr = ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(GRID_COLUMNS) + ADDR_W'(cur_col));
  assign busy      = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    ant_d       = ant_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    valid_d     = 1'b0;
    last_d      = 1'b0;
    px_d        = px_q;
    py_d        = py_q;
    pc_d        = pc_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = fresh;
    ctl.load    = 1'b0;
    ctl.advance = 1'b0;
    ctl.sel     = (state_q == ST_IDLE) ? ANT_W'(ant_index_i) : ant_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (command_i)
            CMD_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
            end
            CMD_LOAD: begin
              ctl.load = (IDXC_W'(ant_index_i) < IDXC_W'(ANT_COUNT));
            end
            CMD_TICK: begin
              state_d = ST_FETCH;
              ant_d   = '0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = PAINT_BLACK;
        if (clr_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = ADDR_W'(clr_q + 1'b1);
        end
      end
      ST_FETCH: begin
        mem_re  = 1'b1;
        addr_d  = cell_addr;
        state_d = ST_PAINT;
      end
      ST_PAINT: begin
        mem_we      = 1'b1;
        ctl.advance = 1'b1;
        valid_d     = 1'b1;
        px_d        = cur_col;
        py_d        = cur_row;
        pc_d        = fresh;
        if (ant_q == ANT_W'(ANT_COUNT - 1)) begin
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ant_d   = ANT_W'(ant_q + 1'b1);
          state_d = ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // reset lands in the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ant_q   <= '0;
      clr_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ant_q   <= ant_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    px_q   <= px_d;
    py_q   <= py_d;
    pc_q   <= pc_d;
  end

  assign result_valid_o = valid_q;
  assign last_of_tick_o = last_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_colour_o = pc_q;

  a_beat_after_paint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == ST_PAINT)
    else $error("result beat without a paint cycle");

  a_beat_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (pixel_x_o < COL_W'(GRID_COLUMNS)) && (pixel_y_o < ROW_W'(GRID_ROWS))
                       && (pixel_colour_o <= PAINT_YELLOW))
    else $error("result beat outside grid or colour range");

  a_last_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_tick_o) |-> state_q == ST_IDLE)
    else $error("last beat while tick still running");

  a_fetch_ant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> ant_q < ANT_W'(ANT_COUNT))
    else $error("ant counter out of range");

  a_paint_follows_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> state_q == ST_PAINT)
    else $error("fetch not followed by paint");

endmodule

`default_nettype wire
